// File: rtl/apsu_pkg.sv
// Shared types, constants and header classification for the parameter-set unit classifier.
package apsu_pkg;

  localparam int BYTE_W  = 8;
  localparam int CODEC_W = 2;
  localparam int COUNT_W = 32;
  localparam int TAG_W   = 42;
  localparam int RUN_W   = 2;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [CODEC_W-1:0] codec_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [RUN_W-1:0]   run_t;

  localparam codec_t CODEC_H264  = 2'd0;
  localparam codec_t CODEC_HEVC  = 2'd1;
  localparam codec_t CODEC_OTHER = 2'd2;

  localparam tag_t   TAG_STEP    = 42'd1000;
  localparam run_t   RUN_MAX     = 2'd3;
  localparam run_t   RUN_START   = 2'd2;
  localparam byte_t  BYTE_ZERO   = 8'h00;
  localparam byte_t  BYTE_ONE    = 8'h01;
  localparam count_t COUNT_LAST  = '1;

  // A NAL header byte is VCL for H.264 when the type is 1 to 5, and for HEVC
  // when the six-bit type is below 32. Any other codec counts as VCL.
  function automatic logic header_is_vcl(input codec_t codec, input byte_t b);
    logic [4:0] avc_type;
    logic [5:0] hevc_type;
    logic       vcl;
    avc_type  = b[4:0];
    hevc_type = b[6:1];
    case (codec)
      CODEC_H264: vcl = (avc_type >= 5'd1) && (avc_type <= 5'd5);
      CODEC_HEVC: vcl = (hevc_type < 6'd32);
      default:    vcl = 1'b1;
    endcase
    return vcl;
  endfunction

endpackage

// File: rtl/apsu_in_if.sv
// Valid/ready channel that carries one access-unit byte per beat.
interface apsu_in_if
  import apsu_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t unit_byte;
  logic  unit_end;

  modport source (output valid, output unit_byte, output unit_end, input ready);
  modport sink   (input valid, input unit_byte, input unit_end, output ready);
endinterface

// File: rtl/apsu_out_if.sv
// Valid/ready channel that carries one per-unit classification result per beat.
interface apsu_out_if
  import apsu_pkg::*;
();
  logic valid;
  logic ready;
  logic param_sets_only;
  logic nal_found;
  tag_t sequence_tag;

  modport source (output valid, output param_sets_only, output nal_found,
                  output sequence_tag, input ready);
  modport sink   (input valid, input param_sets_only, input nal_found,
                  input sequence_tag, output ready);
endinterface

// File: rtl/annexb_param_set_unit_classifier.sv
// Top level of the Annex-B parameter-set unit classifier.
//
//   Channel      Direction  Beat payload
//   -----------  ---------  ----------------------------------------------
//   unit_chan    in         unit_byte[7:0], unit_end
//   result_chan  out        param_sets_only, nal_found, sequence_tag[41:0]
//   cfg_we/wdata in         codec_kind[1:0], written when cfg_we is high
//
// An accepted byte is held in the input register and scanned from there; a byte
// that ends a unit loads the result register when it is scanned, and the result
// is offered from that register. The block sustains one byte per clock; a full
// result register stalls only bytes that end a unit, and the input register
// accepts a new byte in the same cycle it drains. Reset (synchronous, active
// high) clears the scan state, the VCL unit counter, the codec register and
// both valid flags.
module annexb_param_set_unit_classifier
  import apsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  codec_t     cfg_wdata,
  apsu_in_if.sink    unit_chan,
  apsu_out_if.source result_chan
);

  // Codec selection register.
  codec_t codec_kind;

  // Input register stage.
  logic  in_valid;
  byte_t in_byte;
  logic  in_end;

  // Scan state carried across bytes of a unit.
  run_t zero_run, zero_run_next;
  logic expect_header, expect_header_next;
  logic any_nal_seen, any_nal_seen_next;
  logic vcl_seen, vcl_seen_next;

  // The counter and its scaled copy. The copy always equals the counter times
  // the tag step, so no multiplier sits in the result path.
  count_t vcl_unit_count;
  tag_t   tag_base;

  // Result register.
  logic out_valid;
  logic out_ps_only;
  logic out_nal_found;
  tag_t out_tag;

  logic out_free;
  logic scan_go;
  logic known_codec;
  logic ps_only;
  tag_t tag_value;

  assign out_free  = !out_valid || result_chan.ready;
  // A byte that ends a unit needs room in the result register; others never wait.
  assign scan_go   = in_valid && (!in_end || out_free);
  assign unit_chan.ready = !in_valid || scan_go;

  assign result_chan.valid           = out_valid;
  assign result_chan.param_sets_only = out_ps_only;
  assign result_chan.nal_found       = out_nal_found;
  assign result_chan.sequence_tag    = out_tag;

  // Start-code scan for the byte in the input register. The byte after a
  // start code is a header and never counts as a zero.
  always_comb begin
    zero_run_next      = zero_run;
    expect_header_next = expect_header;
    any_nal_seen_next  = any_nal_seen;
    vcl_seen_next      = vcl_seen;
    if (expect_header) begin
      expect_header_next = 1'b0;
      any_nal_seen_next  = 1'b1;
      if (header_is_vcl(codec_kind, in_byte)) begin
        vcl_seen_next = 1'b1;
      end
      zero_run_next = '0;
    end else if (in_byte == BYTE_ZERO) begin
      if (zero_run != RUN_MAX) begin
        zero_run_next = zero_run + run_t'(1);
      end
    end else begin
      if (in_byte == BYTE_ONE && zero_run >= RUN_START) begin
        expect_header_next = 1'b1;
      end
      zero_run_next = '0;
    end
  end

  // Unit summary, formed from the state after this byte is scanned.
  assign known_codec = (codec_kind == CODEC_H264) || (codec_kind == CODEC_HEVC);
  assign ps_only     = known_codec && any_nal_seen_next && !vcl_seen_next;
  assign tag_value   = ps_only ? tag_base : tag_base + TAG_STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_kind <= CODEC_H264;
    end else if (cfg_we) begin
      codec_kind <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (unit_chan.valid && unit_chan.ready) begin
      in_valid <= 1'b1;
    end else if (scan_go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_chan.valid && unit_chan.ready) begin
      in_byte <= unit_chan.unit_byte;
      in_end  <= unit_chan.unit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run       <= '0;
      expect_header  <= 1'b0;
      any_nal_seen   <= 1'b0;
      vcl_seen       <= 1'b0;
      vcl_unit_count <= '0;
      tag_base       <= '0;
    end else if (scan_go) begin
      if (in_end) begin
        // The unit is closed: the scan starts over for the next one.
        zero_run      <= '0;
        expect_header <= 1'b0;
        any_nal_seen  <= 1'b0;
        vcl_seen      <= 1'b0;
        if (!ps_only) begin
          vcl_unit_count <= vcl_unit_count + count_t'(1);
          // The counter wraps to zero, and its scaled copy with it.
          tag_base <= (vcl_unit_count == COUNT_LAST) ? '0 : tag_base + TAG_STEP;
        end
      end else begin
        zero_run      <= zero_run_next;
        expect_header <= expect_header_next;
        any_nal_seen  <= any_nal_seen_next;
        vcl_seen      <= vcl_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_go && in_end) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go && in_end) begin
      out_ps_only   <= ps_only;
      out_nal_found <= any_nal_seen_next;
      out_tag       <= tag_value;
    end
  end

endmodule
